[hw/rtl/fqs_pkg.sv]
package fqs_pkg;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FIND
    } fqs_state_t;

endpackage

[hw/rtl/fqs_ram.sv]
module fqs_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/fifo_queue_with_search_core.sv]
// push, clear and every refused operation: result registered the cycle after the beat is taken
// pop, peek and indexed read: the synchronous ram read is then registered again as the result
// find: one entry per cycle through the single ram read port, until a match or the last entry
// a new beat is taken once the previous operation has finished and the output slot is free
// rst_n is asynchronous and clears pointers, occupancy and output valid
// the entry store itself is not initialised; only entries inside the occupancy reach a result
module fifo_queue_with_search_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fqs_pkg::KIND_W-1:0]   kind,
    input  logic [fqs_pkg::VALUE_W-1:0]  value,
    input  logic [fqs_pkg::POS_W-1:0]    position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fqs_pkg::VALUE_W-1:0]  value_out,
    output logic                         found,
    output logic [fqs_pkg::POS_W-1:0]    found_position,
    output logic [fqs_pkg::COUNT_W-1:0]  entry_count,
    output logic                         is_empty,
    output logic [fqs_pkg::STATUS_W-1:0] status
);

    import fqs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;
    localparam int SUM_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    fqs_state_t state_reg, state_next;

    logic [PTR_W-1:0]      front_reg, front_next;
    logic [PTR_W-1:0]      back_reg, back_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [PTR_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [PTR_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    value_out_reg;
    logic                  found_reg;
    logic [POS_W-1:0]      found_position_reg;
    logic [COUNT_W-1:0]    entry_count_reg;
    logic                  is_empty_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic                  res_load;
    logic [VALUE_W-1:0]    res_value;
    logic                  res_found;
    logic [POS_W-1:0]      res_fpos;
    logic [STATUS_W-1:0]   res_status;

    logic                  ram_we;
    logic [PTR_W-1:0]      ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [PTR_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  in_fire;
    logic                  q_empty;
    logic                  q_full;
    logic                  pos_ok;
    logic [SUM_W-1:0]      pos_sum;
    logic [PTR_W-1:0]      pos_addr;
    logic                  find_match;
    logic                  find_last;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    assign q_empty = (occ_reg == '0);
    assign q_full  = (occ_reg == OCC_W'(DEPTH));
    assign pos_ok  = CMP_W'(position) < CMP_W'(occ_reg);

    // front + position stays below twice the depth whenever the position is in range
    always_comb
    begin
        pos_sum = SUM_W'(front_reg) + SUM_W'(position);
        if (pos_sum >= SUM_W'(DEPTH))
        begin
            pos_sum = pos_sum - SUM_W'(DEPTH);
        end
        pos_addr = pos_sum[PTR_W-1:0];
    end

    assign find_match = (ram_rdata == key_reg);
    assign find_last  = (OCC_W'(cmp_idx_reg) + 1'b1) == occ_reg;

    fqs_ram #(
        .DATA_W (DATA_WIDTH),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (kind)
                        KIND_POP, KIND_PEEK:
                        begin
                            if (!q_empty)
                            begin
                                state_next = S_READ;
                            end
                        end
                        KIND_READ:
                        begin
                            if (!q_empty && pos_ok)
                            begin
                                state_next = S_READ;
                            end
                        end
                        KIND_FIND:
                        begin
                            if (!q_empty)
                            begin
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_FIND:
            begin
                if (find_match || find_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        front_next     = front_reg;
        back_next      = back_reg;
        occ_next       = occ_reg;
        scan_addr_next = scan_addr_reg;
        cmp_idx_next   = cmp_idx_reg;
        key_next       = key_reg;
        ram_we         = 1'b0;
        ram_waddr      = back_reg;
        ram_wdata      = DATA_WIDTH'(value);
        ram_raddr      = front_reg;
        res_load       = 1'b0;
        res_value      = '0;
        res_found      = 1'b0;
        res_fpos       = '0;
        res_status     = STAT_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (kind)
                        KIND_PUSH:
                        begin
                            res_load = 1'b1;
                            if (q_full)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                back_next = ring_next(back_reg);
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (q_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                front_next = ring_next(front_reg);
                                occ_next   = occ_reg - 1'b1;
                            end
                        end
                        KIND_PEEK:
                        begin
                            if (q_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = STAT_EMPTY;
                            end
                        end
                        KIND_FIND:
                        begin
                            key_next       = DATA_WIDTH'(value);
                            scan_addr_next = ring_next(front_reg);
                            cmp_idx_next   = '0;
                            if (q_empty)
                            begin
                                res_load = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            ram_raddr = pos_addr;
                            if (q_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = STAT_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                res_load   = 1'b1;
                                res_status = STAT_RANGE;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            res_load   = 1'b1;
                            front_next = '0;
                            back_next  = '0;
                            occ_next   = '0;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_load  = 1'b1;
                res_value = VALUE_W'(ram_rdata);
            end
            S_FIND:
            begin
                if (find_match)
                begin
                    res_load  = 1'b1;
                    res_found = 1'b1;
                    res_fpos  = POS_W'(cmp_idx_reg);
                end
                else if (find_last)
                begin
                    res_load = 1'b1;
                end
                else
                begin
                    // keep one read in flight while the previous entry is compared
                    ram_raddr      = scan_addr_reg;
                    scan_addr_next = ring_next(scan_addr_reg);
                    cmp_idx_next   = cmp_idx_reg + 1'b1;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        key_reg       <= key_next;
        if (res_load)
        begin
            value_out_reg      <= res_value;
            found_reg          <= res_found;
            found_position_reg <= res_fpos;
            entry_count_reg    <= COUNT_W'(occ_next);
            is_empty_reg       <= (occ_next == '0);
            status_reg         <= res_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value_out      = value_out_reg;
    assign found          = found_reg;
    assign found_position = found_position_reg;
    assign entry_count    = entry_count_reg;
    assign is_empty       = is_empty_reg;
    assign status         = status_reg;

endmodule

[hw/rtl/fqs_checker.sv]
module fqs_checker #(
    parameter int DEPTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [fqs_pkg::KIND_W-1:0]   kind,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [fqs_pkg::VALUE_W-1:0]  value_out,
    input logic                         found,
    input logic [fqs_pkg::POS_W-1:0]    found_position,
    input logic [fqs_pkg::COUNT_W-1:0]  entry_count,
    input logic                         is_empty,
    input logic [fqs_pkg::STATUS_W-1:0] status
);

    import fqs_pkg::*;

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(status)
            && $stable(entry_count))
        else $error("result beat changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (entry_count == '0)) && (DEPTH > 31 || entry_count <= DEPTH))
        else $error("empty flag or entry count inconsistent");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == STAT_OK && value_out == '0
            && (DEPTH > 16 || found_position < entry_count))
        else $error("find result inconsistent");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |-> is_empty && value_out == '0 && !found)
        else $error("empty status on a non-empty queue");

    // a clear beat answers on the next cycle with an empty queue
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_CLEAR |=> out_valid && is_empty
            && status == STAT_OK)
        else $error("clear beat not answered with an empty queue");

endmodule

bind fifo_queue_with_search_core fqs_checker #(.DEPTH(DEPTH)) u_fqs_checker (.*);

[dv/fqs_result_checker.sv]
module fqs_result_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [fqs_pkg::KIND_W-1:0]   kind,
    input  logic [fqs_pkg::VALUE_W-1:0]  value,
    input  logic [fqs_pkg::POS_W-1:0]    position,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [fqs_pkg::VALUE_W-1:0]  value_out,
    input  logic                         found,
    input  logic [fqs_pkg::POS_W-1:0]    found_position,
    input  logic [fqs_pkg::COUNT_W-1:0]  entry_count,
    input  logic                         is_empty,
    input  logic [fqs_pkg::STATUS_W-1:0] status,
    output int                           fail_count,
    output int                           replies_pending,
    output int                           replies_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;

    localparam int QUEUE_DEPTH = 16;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_out;
        logic                found;
        logic [POS_W-1:0]    found_position;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
    } queue_reply_t;

    // shadow copy of the queue
    logic [VALUE_W-1:0] shadow_ring [QUEUE_DEPTH];
    logic [POS_W-1:0]   shadow_head;
    logic [POS_W-1:0]   shadow_tail;
    logic [COUNT_W-1:0] shadow_fill;

    queue_reply_t expected_replies [$];
    queue_reply_t want;

    function automatic queue_reply_t apply_queue_op(
        input logic [KIND_W-1:0]  op,
        input logic [VALUE_W-1:0] word,
        input logic [POS_W-1:0]   pos
    );
        queue_reply_t r;
        logic [POS_W-1:0] slot;
        int i;
        r = '0;
        r.status = STAT_OK;
        case (op)
            KIND_PUSH:
                if (shadow_fill == QUEUE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_ring[shadow_tail] = word;
                    shadow_tail = shadow_tail + 1'b1;
                    shadow_fill = shadow_fill + 1'b1;
                end
            KIND_POP:
                if (shadow_fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.value_out = shadow_ring[shadow_head];
                    shadow_head = shadow_head + 1'b1;
                    shadow_fill = shadow_fill - 1'b1;
                end
            KIND_PEEK:
                if (shadow_fill == 0)
                    r.status = STAT_EMPTY;
                else
                    r.value_out = shadow_ring[shadow_head];
            KIND_FIND:
                for (i = 0; i < shadow_fill; i++)
                begin
                    slot = shadow_head + i[POS_W-1:0];
                    // first match from the front wins
                    if (!r.found && shadow_ring[slot] == word)
                    begin
                        r.found = 1'b1;
                        r.found_position = i[POS_W-1:0];
                    end
                end
            KIND_READ:
                if (shadow_fill == 0)
                    r.status = STAT_EMPTY;
                else if ({1'b0, pos} >= shadow_fill)
                    r.status = STAT_RANGE;
                else
                begin
                    slot = shadow_head + pos;
                    r.value_out = shadow_ring[slot];
                end
            KIND_CLEAR:
            begin
                shadow_head = '0;
                shadow_tail = '0;
                shadow_fill = '0;
            end
            default:
                ;
        endcase
        r.entry_count = shadow_fill;
        r.is_empty = (shadow_fill == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                               input logic [VALUE_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_head = '0;
            shadow_tail = '0;
            shadow_fill = '0;
            expected_replies.delete();
            replies_pending = 0;
            replies_checked = 0;
            fail_count = 0;
        end
        else
        begin
            // output side first so a stray reply is never matched to this edge's request
            if (out_valid && out_ready)
            begin
                if (replies_pending == 0)
                begin
                    $error("reply beat with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    replies_pending--;
                    replies_checked++;
                    check_field("value_out", want.value_out, value_out);
                    check_field("found", want.found, found);
                    check_field("found_position", want.found_position, found_position);
                    check_field("entry_count", want.entry_count, entry_count);
                    check_field("is_empty", want.is_empty, is_empty);
                    check_field("status", want.status, status);
                end
            end
            if (in_valid && in_ready)
            begin
                expected_replies.push_back(apply_queue_op(kind, value, position));
                replies_pending++;
            end
        end
    end

endmodule

[dv/fifo_queue_with_search_core_tb.sv]
module fifo_queue_with_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_OPS   = 900;
    localparam int SETTLE_TIME  = 40;
    localparam int LONG_HOLD    = 400;

    // opcodes the block has no meaning for
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind     = '0;
    logic [VALUE_W-1:0]  value    = '0;
    logic [POS_W-1:0]    position = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [VALUE_W-1:0]  value_out;
    logic                found;
    logic [POS_W-1:0]    found_position;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;

    int fail_count;
    int replies_pending;
    int replies_checked;
    int cycle_count = 0;
    int ops_per_kind [8];

    fifo_queue_with_search_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .value          (value),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value_out      (value_out),
        .found          (found),
        .found_position (found_position),
        .entry_count    (entry_count),
        .is_empty       (is_empty),
        .status         (status)
    );

    fqs_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .value           (value),
        .position        (position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value_out       (value_out),
        .found           (found),
        .found_position  (found_position),
        .entry_count     (entry_count),
        .is_empty        (is_empty),
        .status          (status),
        .fail_count      (fail_count),
        .replies_pending (replies_pending),
        .replies_checked (replies_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_op(input logic [KIND_W-1:0] op, input logic [VALUE_W-1:0] word,
                           input logic [POS_W-1:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        value    <= word;
        position <= pos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ops_per_kind[op]++;
    endtask

    // receiver: random ready pattern plus the occasional long hold to back the queue up
    initial
    begin : reply_sink
        int run_len;
        int stall_len;
        int round;
        round = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            round++;
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = (round % 50 == 10) ? LONG_HOLD : pick_gap();
            if (stall_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [VALUE_W-1:0] fill_words [16];
        logic [VALUE_W-1:0] word_pool [8];
        logic [KIND_W-1:0]  op;
        logic [VALUE_W-1:0] word;
        int mode;
        int push_w;
        int pop_w;
        int r;
        int useful;
        int issued;

        for (int i = 0; i < 8; i++)
            ops_per_kind[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 16; i++)
            fill_words[i] = $urandom();
        fill_words[0]  = '0;
        fill_words[1]  = '1;
        fill_words[2]  = 32'hAAAA_AAAA;
        fill_words[3]  = 32'h5555_5555;
        fill_words[4]  = 32'h8000_0000;
        fill_words[5]  = 32'h0000_0001;
        fill_words[9]  = 32'h1234_5678;
        fill_words[12] = 32'h1234_5678;

        // empty queue corner cases
        send_op(KIND_POP, '0, '0);
        send_op(KIND_PEEK, '1, '1);
        send_op(KIND_READ, '0, '0);
        send_op(KIND_FIND, '0, '0);
        for (int i = 0; i < 16; i++)
            send_op(KIND_PUSH, fill_words[i], i[POS_W-1:0]);
        // full: refused push, duplicate find returns the earlier slot
        send_op(KIND_PUSH, '1, '0);
        send_op(KIND_FIND, fill_words[15], '0);
        send_op(KIND_FIND, 32'h1234_5678, '1);
        send_op(KIND_READ, fill_words[0], 4'd15);
        send_op(KIND_POP, '0, '0);
        send_op(KIND_READ, '0, 4'd15);
        send_op(KIND_CLEAR, '1, '1);

        for (int i = 0; i < 8; i++)
            word_pool[i] = $urandom();
        word_pool[0] = '0;
        word_pool[1] = '1;

        useful = 0;
        issued = 0;
        mode = 2;
        while (useful < RANDOM_OPS)
        begin
            // fill, drain or mixed phases so the queue swings between empty and full
            if (issued % 40 == 0)
                mode = $urandom_range(0, 2);
            push_w = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
            pop_w  = (mode == 0) ? 10 : (mode == 1) ? 45 : 25;
            r = $urandom_range(0, 99);
            if (r < push_w)
                op = KIND_PUSH;
            else if (r < push_w + pop_w)
                op = KIND_POP;
            else
            begin
                r = $urandom_range(0, 19);
                if (r < 7)
                    op = KIND_FIND;
                else if (r < 13)
                    op = KIND_READ;
                else if (r < 17)
                    op = KIND_PEEK;
                else if (r < 18)
                    op = KIND_CLEAR;
                else
                    op = (r == 18) ? KIND_SPARE_LO : KIND_SPARE_HI;
            end
            word = ($urandom_range(0, 9) < 6) ? word_pool[$urandom_range(0, 7)] : $urandom();
            send_op(op, word, POS_W'($urandom_range(0, 15)));
            issued++;
            if (op != KIND_SPARE_LO && op != KIND_SPARE_HI)
                useful++;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (replies_pending != 0) @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);

        $display("ran %0d push, %0d pop, %0d peek, %0d find, %0d read, %0d clear, %0d spare",
                 ops_per_kind[KIND_PUSH], ops_per_kind[KIND_POP], ops_per_kind[KIND_PEEK],
                 ops_per_kind[KIND_FIND], ops_per_kind[KIND_READ], ops_per_kind[KIND_CLEAR],
                 ops_per_kind[KIND_SPARE_LO] + ops_per_kind[KIND_SPARE_HI]);
        $display("%0d replies checked over fill and drain phases with long output holds",
                 replies_checked);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
